// File: rtl/dlb_pkg.sv
// shared types, opcodes and constants for the dual led blink and glow controller
`timescale 1ns / 1ps

package dlb_pkg;

   localparam int unsigned TimeW     = 32;
   localparam int unsigned DurW      = 20;
   localparam int unsigned IntervalW = 16;
   localparam int unsigned OpW       = 4;
   localparam int unsigned ModeW     = 2;
   localparam int unsigned CsrIdxW   = 1;
   localparam int unsigned CsrDataW  = 20;

   localparam logic [OpW-1:0] OP_TICK        = 4'd0;
   localparam logic [OpW-1:0] OP_RED_BLINK   = 4'd1;
   localparam logic [OpW-1:0] OP_GREEN_BLINK = 4'd2;
   localparam logic [OpW-1:0] OP_RED_GLOW    = 4'd3;
   localparam logic [OpW-1:0] OP_GREEN_GLOW  = 4'd4;
   localparam logic [OpW-1:0] OP_RED_OFF     = 4'd5;
   localparam logic [OpW-1:0] OP_GREEN_OFF   = 4'd6;
   localparam logic [OpW-1:0] OP_DOOR_OPEN   = 4'd7;
   localparam logic [OpW-1:0] OP_DOOR_CLOSE  = 4'd8;
   localparam logic [OpW-1:0] OP_DOOR_CLEAR  = 4'd9;

   localparam logic [ModeW-1:0] MODE_IDLE  = 2'd0;
   localparam logic [ModeW-1:0] MODE_BLINK = 2'd1;
   localparam logic [ModeW-1:0] MODE_GLOW  = 2'd2;

   localparam logic [CsrIdxW-1:0] CSR_BLINK_INTERVAL = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_DOOR_TIMEOUT   = 1'd1;

   localparam logic [IntervalW-1:0] BLINK_INTERVAL_RESET = 16'd250;
   localparam logic [DurW-1:0]      DOOR_TIMEOUT_RESET   = 20'd15000;

   typedef struct packed {
      logic [OpW-1:0]  op;
      logic [DurW-1:0] duration;
   } req_payload_type;

   typedef struct packed {
      logic             red_led;
      logic             green_led;
      logic [ModeW-1:0] red_mode_out;
      logic [ModeW-1:0] green_mode_out;
      logic             door_open_flag;
   } rsp_payload_type;

   typedef struct packed {
      logic            accept;
      logic            tick;
      logic            blink;
      logic            glow;
      logic            off;
      logic            force_glow;
      logic [DurW-1:0] duration;
   } chan_ctrl_type;

   typedef struct packed {
      logic [ModeW-1:0] mode;
      logic             drive;
   } chan_status_type;

endpackage

// File: rtl/dlb_led_chan.sv
// one led channel: mode, blink phase, toggle time and end time
`timescale 1ns / 1ps

module dlb_led_chan (
   input  logic                                clock,
   input  logic                                reset,
   input  dlb_pkg::chan_ctrl_type              ctrl,
   input  logic [dlb_pkg::TimeW-1:0]           now,
   input  logic [dlb_pkg::IntervalW-1:0]       interval,
   output dlb_pkg::chan_status_type            status_nx
);
   import dlb_pkg::*;

   logic [ModeW-1:0] mode_ff, mode_in;
   logic             phase_ff, phase_in;
   logic             drive_ff, drive_in;
   logic [TimeW-1:0] last_ff, last_in;
   logic [TimeW-1:0] end_ff, end_in;

   logic [TimeW-1:0] elapsed;
   logic [TimeW-1:0] end_sum;
   logic             expired;

   assign elapsed = now - last_ff;
   assign end_sum = now + {{(TimeW-DurW){1'b0}}, ctrl.duration};
   assign expired = now >= end_ff;

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      drive_in = drive_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      if (ctrl.tick) begin
         case (mode_ff)
            MODE_BLINK: begin
               if (expired) begin
                  mode_in  = MODE_IDLE;
                  drive_in = 1'b0;
               end else if (elapsed >= {{(TimeW-IntervalW){1'b0}}, interval}) begin
                  last_in  = now;
                  phase_in = ~phase_ff;
                  drive_in = ~phase_ff;
               end
            end
            MODE_GLOW: begin
               if (expired) begin
                  mode_in  = MODE_IDLE;
                  drive_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
         // door timer restarts a red glow whenever red is not already glowing, even over a blink
         if (ctrl.force_glow && (mode_in != MODE_GLOW)) begin
            mode_in  = MODE_GLOW;
            end_in   = end_sum;
            drive_in = 1'b1;
         end
      end else if (ctrl.blink) begin
         mode_in  = MODE_BLINK;
         phase_in = 1'b0;
         last_in  = now;
         end_in   = end_sum;
         drive_in = 1'b0;
      end else if (ctrl.glow) begin
         mode_in  = MODE_GLOW;
         end_in   = end_sum;
         drive_in = 1'b1;
      end else if (ctrl.off) begin
         mode_in  = MODE_IDLE;
         drive_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         phase_ff <= 1'b0;
         drive_ff <= 1'b0;
         last_ff  <= '0;
         end_ff   <= '0;
      end else if (ctrl.accept) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         drive_ff <= drive_in;
         last_ff  <= last_in;
         end_ff   <= end_in;
      end
   end

   assign status_nx.mode  = mode_in;
   assign status_nx.drive = drive_in;

endmodule

// File: rtl/dual_led_timed_blink_glow.sv
// top level: millisecond clock, door timer, two led channels and result register
// an accepted request beat gives its response beat, registered, in the next cycle
// throughput: one beat per cycle while req_stall is low; every op updates state in a single pass
// req_stall is high only while a response beat waits under rsp_stall
// reset (synchronous, active high) idles both leds, clears the clock and door timer
// and restores blink interval 250 and door timeout 15000
`timescale 1ns / 1ps

module dual_led_timed_blink_glow (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dlb_pkg::req_payload_type           req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dlb_pkg::rsp_payload_type           rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dlb_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [dlb_pkg::CsrDataW-1:0]       csr_wdata
);
   import dlb_pkg::*;

   logic [IntervalW-1:0] interval_ff;
   logic [DurW-1:0]      timeout_ff;
   logic [TimeW-1:0]     clock_ff, clock_in;
   logic                 door_ff, door_in;
   logic [TimeW-1:0]     door_start_ff, door_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            is_tick;
   logic [TimeW-1:0] door_elapsed;
   logic            door_due;
   chan_ctrl_type   red_ctrl, green_ctrl;
   chan_status_type red_nx, green_nx;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign csr_ready = 1'b1;
   assign is_tick   = req_data.op == OP_TICK;
   assign clock_in  = is_tick ? clock_ff + TimeW'(1) : clock_ff;

   assign door_elapsed = clock_in - door_start_ff;
   assign door_due     = door_ff &&
                         (door_elapsed > {{(TimeW-DurW){1'b0}}, timeout_ff});

   always_comb begin
      red_ctrl.accept     = accept;
      red_ctrl.tick       = is_tick;
      red_ctrl.blink      = req_data.op == OP_RED_BLINK;
      red_ctrl.glow       = req_data.op == OP_RED_GLOW;
      red_ctrl.off        = (req_data.op == OP_RED_OFF) || (req_data.op == OP_DOOR_CLOSE);
      red_ctrl.force_glow = door_due;
      red_ctrl.duration   = is_tick ? timeout_ff : req_data.duration;

      green_ctrl.accept     = accept;
      green_ctrl.tick       = is_tick;
      green_ctrl.blink      = req_data.op == OP_GREEN_BLINK;
      green_ctrl.glow       = req_data.op == OP_GREEN_GLOW;
      green_ctrl.off        = req_data.op == OP_GREEN_OFF;
      green_ctrl.force_glow = 1'b0;
      green_ctrl.duration   = req_data.duration;
   end

   dlb_led_chan u_red (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (red_ctrl),
      .now       (clock_in),
      .interval  (interval_ff),
      .status_nx (red_nx)
   );

   dlb_led_chan u_green (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (green_ctrl),
      .now       (clock_in),
      .interval  (interval_ff),
      .status_nx (green_nx)
   );

   always_comb begin
      door_in       = door_ff;
      door_start_in = door_start_ff;
      case (req_data.op)
         OP_DOOR_OPEN: begin
            door_in       = 1'b1;
            door_start_in = clock_ff;
         end
         OP_DOOR_CLOSE, OP_DOOR_CLEAR: begin
            door_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in.red_led        = red_nx.drive;
      rsp_data_in.green_led      = green_nx.drive;
      rsp_data_in.red_mode_out   = red_nx.mode;
      rsp_data_in.green_mode_out = green_nx.mode;
      rsp_data_in.door_open_flag = door_in;
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff   <= BLINK_INTERVAL_RESET;
         timeout_ff    <= DOOR_TIMEOUT_RESET;
         clock_ff      <= '0;
         door_ff       <= 1'b0;
         door_start_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BLINK_INTERVAL: interval_ff <= csr_wdata[IntervalW-1:0];
               CSR_DOOR_TIMEOUT:   timeout_ff  <= csr_wdata[DurW-1:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            clock_ff      <= clock_in;
            door_ff       <= door_in;
            door_start_ff <= door_start_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (accept && is_tick) |=> (clock_ff == $past(clock_ff) + TimeW'(1)))
      else $error("clock did not advance on tick beat");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted beat produced no response");

   a_door_close: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.op == OP_DOOR_CLOSE)) |=>
      ((rsp_data.red_mode_out == MODE_IDLE) && !rsp_data.red_led && !rsp_data.door_open_flag))
      else $error("door close left red or door flag active");

   a_glow_lit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.red_mode_out == MODE_GLOW)) |-> rsp_data.red_led)
      else $error("red glowing but led off");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.red_mode_out != 2'd3) && (rsp_data.green_mode_out != 2'd3)))
      else $error("illegal led mode in response");

endmodule
